@@ rtl/http_request_head_parser_assert.svh @@
// Assertion macros for the request head parser.
`ifndef HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define HRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define HRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hrp_pkg.sv @@
// Shared types, codes and helpers for the request head parser.
package hrp_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int CFG_INDEX_BITS     = 3;
    localparam int CFG_DATA_BITS      = 16;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CTRL_MAX   = 8'h1F;  // highest plain control byte

    typedef enum logic [2:0] {
        CFG_METHOD_LIMIT  = 3'd0,
        CFG_PATH_LIMIT    = 3'd1,
        CFG_QUERY_LIMIT   = 3'd2,
        CFG_VERSION_LIMIT = 3'd3,
        CFG_HEADER_LIMIT  = 3'd4,
        CFG_HIGH_INVALID  = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        FK_METHOD    = 3'd0,
        FK_PATH      = 3'd1,
        FK_QUERY     = 3'd2,
        FK_VERSION   = 3'd3,
        FK_HEADER    = 3'd4,
        FK_BODY      = 3'd5,
        FK_DELIM     = 3'd6,
        FK_DISCARDED = 3'd7
    } field_kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,  // 200
        ST_BAD      = 3'd1,  // 400
        ST_NOTIMPL  = 3'd2,  // 501
        ST_URI      = 3'd3,  // 414
        ST_VERSION  = 3'd4,  // 505
        ST_HEADERS  = 3'd5   // 431
    } status_t;

    typedef struct packed {
        logic [7:0]  method_limit;
        logic [11:0] path_limit;
        logic [11:0] query_limit;
        logic [7:0]  version_limit;
        logic [15:0] header_limit;
        logic        high_bytes_invalid;
    } cfg_t;

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
            return b + 8'd32;
        end
        return b;
    endfunction

    function automatic logic is_ctrl(input logic [7:0] b, input logic high_invalid);
        return (b <= CTRL_MAX) || (b[7] && high_invalid);
    endfunction

endpackage

@@ rtl/hrp_cfg_regs.sv @@
// Configuration register file for the request head parser.
module hrp_cfg_regs
    import hrp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.method_limit       <= 8'd8;
            cfg_reg.path_limit         <= 12'd128;
            cfg_reg.query_limit        <= 12'd256;
            cfg_reg.version_limit      <= 8'd16;
            cfg_reg.header_limit       <= 16'd2048;
            cfg_reg.high_bytes_invalid <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                CFG_METHOD_LIMIT:  cfg_reg.method_limit       <= cfg_wdata[7:0];
                CFG_PATH_LIMIT:    cfg_reg.path_limit         <= cfg_wdata[11:0];
                CFG_QUERY_LIMIT:   cfg_reg.query_limit        <= cfg_wdata[11:0];
                CFG_VERSION_LIMIT: cfg_reg.version_limit      <= cfg_wdata[7:0];
                CFG_HEADER_LIMIT:  cfg_reg.header_limit       <= cfg_wdata[15:0];
                CFG_HIGH_INVALID:  cfg_reg.high_bytes_invalid <= cfg_wdata[0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/http_request_head_parser.sv @@
// A byte accepted at one edge shows its registered result item in the cycle after.
// Throughput: one byte per cycle; the output register stalls input only when
// a result is held and m_ready is low. Parse state advances once per byte.
// Reset (aresetn low, synchronous) clears the parse state and output valid and
// loads the register defaults. A last byte returns the parse state to reset;
// configuration keeps its values.
`include "http_request_head_parser_assert.svh"

module http_request_head_parser
    import hrp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_data_byte,
    input  logic                      s_last_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_out_byte,
    output logic [2:0]                m_field_kind,
    output logic                      m_decided,
    output logic                      m_request_done,
    output logic [2:0]                m_status,
    output logic [15:0]               m_body_length
);

    localparam int CMP_BITS  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int BODY_BITS = (COUNT_BITS < 16) ? COUNT_BITS : 16;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_PATH    = 3'd1,
        PH_QUERY   = 3'd2,
        PH_VERSION = 3'd3,
        PH_HEADER  = 3'd4,
        PH_BODY    = 3'd5
    } phase_t;

    cfg_t cfg;

    hrp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // parse state
    phase_t                 phase_reg, phase_next;
    logic [2:0]             ler_reg, ler_next;
    logic [COUNT_BITS-1:0]  fc_reg, fc_next;
    logic                   key_reg, key_next;
    logic                   fixed_reg, fixed_next;
    status_t                latch_reg, latch_next;
    logic [BODY_BITS-1:0]   bc_reg, bc_next;

    // result register
    logic                   m_valid_reg;
    logic [7:0]             ob_reg, ob_next;
    field_kind_t            kind_reg, kind_next;
    logic                   decided_reg, decided_next;
    logic                   done_reg;
    status_t                status_reg, status_next;
    logic [BODY_BITS-1:0]   blen_reg, blen_next;

    logic accept;

    function automatic logic [CMP_BITS-1:0] limit_of(input phase_t ph, input cfg_t c);
        unique case (ph)
            PH_METHOD:  return CMP_BITS'(c.method_limit);
            PH_PATH:    return CMP_BITS'(c.path_limit);
            PH_QUERY:   return CMP_BITS'(c.query_limit);
            PH_VERSION: return CMP_BITS'(c.version_limit);
            default:    return CMP_BITS'(c.header_limit);
        endcase
    endfunction

    function automatic status_t field_error(input phase_t ph, input logic [2:0] ler,
                                            input logic fc_zero);
        unique case (ph)
            PH_METHOD:  return ST_NOTIMPL;
            PH_PATH:    return ST_URI;
            PH_QUERY:   return ST_URI;
            PH_VERSION: return (ler == 3'd0 || fc_zero) ? ST_VERSION : ST_BAD;
            PH_HEADER:  return (ler >= 3'd3) ? ST_BAD : ST_HEADERS;
            default:    return ST_OK;
        endcase
    endfunction

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        logic [7:0]            b;
        logic                  ctl;
        logic                  lineend;
        logic                  fc_max;
        b       = s_data_byte;
        ctl     = is_ctrl(b, cfg.high_bytes_invalid);
        lineend = (b == CHAR_CR) || (b == CHAR_LF);
        fc_max  = &fc_reg;

        phase_next = phase_reg;
        ler_next   = ler_reg;
        fc_next    = fc_reg;
        key_next   = key_reg;
        fixed_next = fixed_reg;
        latch_next = latch_reg;
        bc_next    = bc_reg;
        ob_next    = b;
        kind_next  = FK_DISCARDED;

        if (fixed_reg) begin
            if (phase_reg == PH_BODY) begin
                kind_next = FK_BODY;
                if (!(&bc_reg)) begin
                    bc_next = bc_reg + 1'b1;
                end
            end
        end else if (phase_reg != PH_BODY &&
                     CMP_BITS'(fc_reg) >= limit_of(phase_reg, cfg)) begin
            // limit lowered under a running field
            fixed_next = 1'b1;
            latch_next = field_error(phase_reg, ler_reg, fc_reg == '0);
        end else begin
            unique case (phase_reg)
                PH_METHOD: begin
                    ob_next = to_lower(b);
                    if (b == CHAR_SPACE) begin
                        kind_next = FK_DELIM;
                        if (fc_reg == '0) begin
                            fixed_next = 1'b1;
                            latch_next = ST_NOTIMPL;
                        end else begin
                            phase_next = PH_PATH;
                            fc_next    = '0;
                        end
                    end else begin
                        kind_next = FK_METHOD;
                        if (ctl) begin
                            fixed_next = 1'b1;
                            latch_next = ST_BAD;
                        end else if (!fc_max) begin
                            fc_next = fc_reg + 1'b1;
                        end
                    end
                end
                PH_PATH: begin
                    if (b == CHAR_QMARK || b == CHAR_SPACE) begin
                        kind_next = FK_DELIM;
                        if (fc_reg == '0) begin
                            fixed_next = 1'b1;
                            latch_next = ST_URI;
                        end else begin
                            phase_next = (b == CHAR_QMARK) ? PH_QUERY : PH_VERSION;
                            fc_next    = '0;
                            ler_next   = 3'd0;
                        end
                    end else begin
                        kind_next = FK_PATH;
                        if (ctl) begin
                            fixed_next = 1'b1;
                            latch_next = ST_BAD;
                        end else if (!fc_max) begin
                            fc_next = fc_reg + 1'b1;
                        end
                    end
                end
                PH_QUERY: begin
                    if (b == CHAR_SPACE) begin
                        kind_next  = FK_DELIM;
                        phase_next = PH_VERSION;
                        fc_next    = '0;
                        ler_next   = 3'd0;
                    end else begin
                        kind_next = FK_QUERY;
                        if (ctl) begin
                            fixed_next = 1'b1;
                            latch_next = ST_BAD;
                        end else if (!fc_max) begin
                            fc_next = fc_reg + 1'b1;
                        end
                    end
                end
                PH_VERSION: begin
                    ob_next = to_lower(b);
                    if (lineend) begin
                        kind_next = FK_DELIM;
                        ler_next  = ler_reg + 3'd1;
                        if (ler_reg >= 3'd1) begin
                            if (fc_reg == '0) begin
                                fixed_next = 1'b1;
                                latch_next = ST_VERSION;
                            end else begin
                                phase_next = PH_HEADER;
                                fc_next    = '0;
                                ler_next   = 3'd2;  // version line end starts the run
                            end
                        end
                    end else begin
                        kind_next = FK_VERSION;
                        if (ctl) begin
                            fixed_next = 1'b1;
                            latch_next = ST_BAD;
                        end else if (!fc_max) begin
                            fc_next = fc_reg + 1'b1;
                        end
                    end
                end
                PH_HEADER: begin
                    kind_next = FK_HEADER;
                    if (key_reg) begin
                        ob_next = to_lower(b);
                    end
                    if (b == CHAR_COLON) begin
                        key_next = 1'b0;
                    end
                    if (lineend) begin
                        key_next = 1'b1;
                        ler_next = ler_reg + 3'd1;
                    end else if (ctl) begin
                        fixed_next = 1'b1;
                        latch_next = ST_BAD;
                    end else begin
                        ler_next = 3'd0;
                    end
                    if (!fixed_next) begin
                        if (!fc_max) begin
                            fc_next = fc_reg + 1'b1;
                        end
                        if (ler_next >= 3'd4) begin
                            // blank line: header end
                            fixed_next = 1'b1;
                            latch_next = ST_OK;
                            phase_next = PH_BODY;
                            ler_next   = 3'd0;
                        end
                    end
                end
                default: ;
            endcase
            if (!fixed_next && phase_next != PH_BODY &&
                CMP_BITS'(fc_next) >= limit_of(phase_next, cfg)) begin
                fixed_next = 1'b1;
                latch_next = field_error(phase_next, ler_next, fc_next == '0);
            end
        end

        decided_next = fixed_next;
        status_next  = ST_OK;
        blen_next    = '0;
        if (s_last_byte) begin
            status_next = fixed_next ? latch_next
                                     : field_error(phase_next, ler_next, fc_next == '0);
            blen_next   = bc_next;
            phase_next  = PH_METHOD;
            ler_next    = 3'd0;
            fc_next     = '0;
            key_next    = 1'b1;
            fixed_next  = 1'b0;
            latch_next  = ST_OK;
            bc_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_METHOD;
            ler_reg     <= 3'd0;
            fc_reg      <= '0;
            key_reg     <= 1'b1;
            fixed_reg   <= 1'b0;
            latch_reg   <= ST_OK;
            bc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                ler_reg     <= ler_next;
                fc_reg      <= fc_next;
                key_reg     <= key_next;
                fixed_reg   <= fixed_next;
                latch_reg   <= latch_next;
                bc_reg      <= bc_next;
                ob_reg      <= ob_next;
                kind_reg    <= kind_next;
                decided_reg <= decided_next;
                done_reg    <= s_last_byte;
                status_reg  <= status_next;
                blen_reg    <= blen_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = ob_reg;
    assign m_field_kind   = kind_reg;
    assign m_decided      = decided_reg;
    assign m_request_done = done_reg;
    assign m_status       = status_reg;
    assign m_body_length  = 16'(blen_reg);

    `HRP_ASSERT_NOW(a_body_fixed, phase_reg == PH_BODY, fixed_reg, "body phase undecided")
    `HRP_ASSERT_NOW(a_body_decided, m_valid && kind_reg == FK_BODY, m_decided, "body undecided")
    `HRP_ASSERT_NOW(a_status_done, m_valid && !done_reg, status_reg == ST_OK, "status not done")
    `HRP_ASSERT_NEXT(a_done_clears, accept && s_last_byte, !fixed_reg, "state not cleared")

endmodule
